[design/imrm_pkg.sv]
// Package for the image region mirror unit.
// Holds frame geometry constants, register indexes, mode codes, shared types
// and the size and corner clamp functions. No dependencies.
package imrm_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Fixed field widths
  localparam int CRD_W   = 9;   // column and row coordinates
  localparam int SIZE_W  = 10;  // image_width / image_height registers
  localparam int CORN_W  = 16;  // region corner registers
  localparam int MODE_W  = 2;
  localparam int COMP_W  = 8;
  localparam int PIX_W   = 3 * COMP_W;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;

  // Stream packing
  localparam int IN_DATA_W  = 48;  // column, row, red, green, blue, pad
  localparam int OUT_DATA_W = 32;  // red, green, blue, in_range, pad

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_LEFT_COLUMN  = 3'd1,
    CFG_TOP_ROW      = 3'd2,
    CFG_RIGHT_COLUMN = 3'd3,
    CFG_BOTTOM_ROW   = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_index_t;

  // Mirror modes (the fourth code behaves like no mirror)
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROWS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COLS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register file contents
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [CORN_W-1:0] left_column;
    logic signed [CORN_W-1:0] top_row;
    logic signed [CORN_W-1:0] right_column;
    logic signed [CORN_W-1:0] bottom_row;
    logic [SIZE_W-1:0]        image_width;
    logic [SIZE_W-1:0]        image_height;
  } cfg_regs_t;

  // Memory access decided by the address mapper
  typedef struct packed {
    logic              ok;   // coordinate inside the image
    logic              wr;   // store the pixel
    logic              rd;   // fetch a pixel
    logic [ADDR_W-1:0] addr;
  } access_t;

  // Zero becomes one, anything above the maximum becomes the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int max_size);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > max_size) begin
      res = SIZE_W'(max_size);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Negative goes to 0, at or past the size goes to size-1
  function automatic logic [CRD_W-1:0] clamp_corner(logic signed [CORN_W-1:0] v,
                                                     logic [SIZE_W-1:0] size);
    logic signed [CORN_W:0] vx;
    logic signed [CORN_W:0] sx;
    logic [SIZE_W-1:0]      lim;
    logic [CRD_W-1:0]       res;
    vx  = {v[CORN_W-1], v};
    sx  = $signed({{(CORN_W + 1 - SIZE_W){1'b0}}, size});
    lim = size - SIZE_W'(1);
    if (vx < 0) begin
      res = '0;
    end else if (vx >= sx) begin
      res = CRD_W'(lim);
    end else begin
      res = CRD_W'(vx);
    end
    return res;
  endfunction

endpackage

[design/imrm_map.sv]
// Address mapper: range check, region clamp and mirror of the coordinate.
// Turns one item into a frame store access. Depends on imrm_pkg.
module imrm_map import imrm_pkg::*; (
  input  cfg_regs_t        cfg,
  input  logic             opcode,
  input  logic [CRD_W-1:0] column,
  input  logic [CRD_W-1:0] row,
  output access_t          acc
);

  logic [SIZE_W-1:0] width_use;
  logic [SIZE_W-1:0] height_use;
  logic [CRD_W-1:0]  left;
  logic [CRD_W-1:0]  right;
  logic [CRD_W-1:0]  top;
  logic [CRD_W-1:0]  bottom;
  logic              ok;
  logic              in_region;
  logic [CRD_W+1:0]  row_sum;
  logic [CRD_W+1:0]  col_sum;
  logic [CRD_W-1:0]  src_row;
  logic [CRD_W-1:0]  src_col;

  // Effective image size and clamped region
  assign width_use  = clamp_size(cfg.image_width, MAX_WIDTH);
  assign height_use = clamp_size(cfg.image_height, MAX_HEIGHT);
  assign left       = clamp_corner(cfg.left_column, width_use);
  assign right      = clamp_corner(cfg.right_column, width_use);
  assign top        = clamp_corner(cfg.top_row, height_use);
  assign bottom     = clamp_corner(cfg.bottom_row, height_use);

  assign ok = ({1'b0, column} < width_use) && ({1'b0, row} < height_use);

  assign in_region = (left <= right) && (top <= bottom) &&
                     (column >= left) && (column <= right) &&
                     (row >= top) && (row <= bottom);

  // Mirror within the region; result stays inside it, so it fits
  assign row_sum = {2'b00, bottom} + {2'b00, top} - {2'b00, row};
  assign col_sum = {2'b00, right} + {2'b00, left} - {2'b00, column};

  always_comb begin
    src_row = row;
    src_col = column;
    if (in_region && opcode == OP_READ) begin
      case (cfg.mode)
        MODE_ROWS: src_row = row_sum[CRD_W-1:0];
        MODE_COLS: src_col = col_sum[CRD_W-1:0];
        default:   ;
      endcase
    end
  end

  assign acc.ok   = ok;
  assign acc.wr   = ok && (opcode == OP_WRITE);
  assign acc.rd   = ok && (opcode == OP_READ);
  assign acc.addr = ADDR_W'(int'(src_row) * MAX_WIDTH + int'(src_col));

endmodule

[design/imrm_ram.sv]
// Frame store: single-port synchronous RAM of RGB pixels, one access a cycle,
// read data registered. Depends on imrm_pkg.
module imrm_ram import imrm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[design/image_region_mirror_unit.sv]
// Image region mirror unit: RGB frame store with mirrored reads in a region.
// The result is valid in the cycle after the item is accepted.
// One item at a time: a new item is taken only after the last result is accepted;
// the single RAM port and the one output register hold one item at a time.
// Reset (rst, synchronous): registers go to their defaults, no item held;
// frame store contents are not cleared and are undefined until written.
module image_region_mirror_unit import imrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // Input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // column[8:0] row[17:9] red_in[25:18]
                                           // green_in[33:26] blue_in[41:34] zero pad
  input  logic [0:0]            s_tuser,   // opcode[0]
  // Result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // red_out[7:0] green_out[15:8]
                                           // blue_out[23:16] in_range[24] zero pad
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  cfg_regs_t         cfg;
  access_t           acc;
  logic              accept;
  logic              mem_en;
  logic [PIX_W-1:0]  mem_q;
  logic              out_ok;
  logic              out_rd;
  logic [PIX_W-1:0]  pix;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_NONE;
      cfg.left_column  <= '0;
      cfg.top_row      <= '0;
      cfg.right_column <= '0;
      cfg.bottom_row   <= '0;
      cfg.image_width  <= SIZE_W'(512);
      cfg.image_height <= SIZE_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:         cfg.mode         <= cfg_data[MODE_W-1:0];
        CFG_LEFT_COLUMN:  cfg.left_column  <= $signed(cfg_data[CORN_W-1:0]);
        CFG_TOP_ROW:      cfg.top_row      <= $signed(cfg_data[CORN_W-1:0]);
        CFG_RIGHT_COLUMN: cfg.right_column <= $signed(cfg_data[CORN_W-1:0]);
        CFG_BOTTOM_ROW:   cfg.bottom_row   <= $signed(cfg_data[CORN_W-1:0]);
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Coordinate check and mirror
  imrm_map u_map (
    .cfg    (cfg),
    .opcode (s_tuser[0]),
    .column (s_tdata[8:0]),
    .row    (s_tdata[17:9]),
    .acc    (acc)
  );

  assign accept = s_tvalid && s_tready;
  assign mem_en = accept && (acc.wr || acc.rd);

  // Frame store, pixel kept as {red, green, blue}
  imrm_ram u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (acc.wr),
    .addr  (acc.addr),
    .wdata ({s_tdata[25:18], s_tdata[33:26], s_tdata[41:34]}),
    .rdata (mem_q)
  );

  // Handshake sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-item flags, captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok <= acc.ok;
      out_rd <= acc.rd;
    end
  end

  // RAM output holds until the next read, which needs a new item
  assign pix      = out_rd ? mem_q : '0;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(OUT_DATA_W - PIX_W - 1){1'b0}}, out_ok,
                     pix[COMP_W-1:0], pix[2*COMP_W-1:COMP_W], pix[PIX_W-1:2*COMP_W]};

  // Checks
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_outside_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[PIX_W]) |-> (m_tdata[PIX_W-1:0] == '0))
    else $error("out-of-image item carries nonzero pixel");

  a_ram_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    mem_en |-> (acc.ok && state == ST_IDLE))
    else $error("frame store accessed outside an accepted in-range item");

endmodule

[test/image_region_mirror_checker.sv]
// Checker for the image region mirror unit: watches the config port and both
// item streams, predicts each result from its own frame store copy and compares.
// Depends on imrm_pkg for widths, register indexes, mode and opcode codes.
module image_region_mirror_checker import imrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              in_range;
  } pixel_result_t;

  cfg_regs_t         regs;
  logic [PIX_W-1:0]  frame_copy [int];
  pixel_result_t     pending_pixels [$];
  int                fail_count = 0;

  // Size register as the unit uses it: zero reads as one, capped at the maximum
  function automatic int usable_size(logic [SIZE_W-1:0] v, int max_size);
    if (v == '0) return 1;
    return (int'(v) > max_size) ? max_size : int'(v);
  endfunction

  // Corner pulled into [0, size-1]
  function automatic int fit_corner(logic signed [CORN_W-1:0] v, int size);
    int c;
    c = v;
    if (c < 0) return 0;
    return (c >= size) ? size - 1 : c;
  endfunction

  // Expected result of one item; writes update the frame copy
  function automatic pixel_result_t mirror_predict(logic op, int col, int row,
                                                   logic [PIX_W-1:0] rgb);
    pixel_result_t res;
    int w, h, lc, rc, tr, br, sc, sr;
    logic [PIX_W-1:0] pix;
    res = '0;
    pix = '0;
    w = usable_size(regs.image_width, MAX_WIDTH);
    h = usable_size(regs.image_height, MAX_HEIGHT);
    res.in_range = (col < w) && (row < h);
    if (res.in_range) begin
      if (op == OP_WRITE) begin
        frame_copy[row * MAX_WIDTH + col] = rgb;
      end else begin
        lc = fit_corner(regs.left_column, w);
        rc = fit_corner(regs.right_column, w);
        tr = fit_corner(regs.top_row, h);
        br = fit_corner(regs.bottom_row, h);
        sc = col;
        sr = row;
        if (lc <= rc && tr <= br && col >= lc && col <= rc && row >= tr && row <= br) begin
          if (regs.mode == MODE_ROWS) sr = br + tr - row;
          else if (regs.mode == MODE_COLS) sc = rc + lc - col;
        end
        if (frame_copy.exists(sr * MAX_WIDTH + sc)) pix = frame_copy[sr * MAX_WIDTH + sc];
      end
    end
    res.red   = pix[23:16];
    res.green = pix[15:8];
    res.blue  = pix[7:0];
    return res;
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  // Predict on accepted input items, compare on accepted result items
  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (rst) begin
      regs.mode         = MODE_NONE;
      regs.left_column  = '0;
      regs.top_row      = '0;
      regs.right_column = '0;
      regs.bottom_row   = '0;
      regs.image_width  = SIZE_W'(MAX_WIDTH);
      regs.image_height = SIZE_W'(MAX_HEIGHT);
      pending_pixels.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pending_pixels.push_back(mirror_predict(s_tuser[0], int'(s_tdata[8:0]),
                                                int'(s_tdata[17:9]),
                                                {s_tdata[25:18], s_tdata[33:26],
                                                 s_tdata[41:34]}));
      end
      if (m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected result item: tdata %h", m_tdata);
          fail_count++;
        end else begin
          exp_res = pending_pixels.pop_front();
          check_field("red_out", exp_res.red, m_tdata[7:0]);
          check_field("green_out", exp_res.green, m_tdata[15:8]);
          check_field("blue_out", exp_res.blue, m_tdata[23:16]);
          check_field("in_range", exp_res.in_range, m_tdata[24]);
        end
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_MODE:         regs.mode         = cfg_data[MODE_W-1:0];
          CFG_LEFT_COLUMN:  regs.left_column  = cfg_data[CORN_W-1:0];
          CFG_TOP_ROW:      regs.top_row      = cfg_data[CORN_W-1:0];
          CFG_RIGHT_COLUMN: regs.right_column = cfg_data[CORN_W-1:0];
          CFG_BOTTOM_ROW:   regs.bottom_row   = cfg_data[CORN_W-1:0];
          CFG_IMAGE_WIDTH:  regs.image_width  = cfg_data[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT: regs.image_height = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_pixels.size();
  end

endmodule

[test/tb_top.sv]
// Top of the image region mirror unit testbench: clock, reset, config writes
// and item stimulus with random gaps and stalls; the checker gives the verdict count.
// Depends on imrm_pkg, image_region_mirror_unit and image_region_mirror_checker.
module tb_top;
  import imrm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 50;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    mismatches;
  int                    outstanding;

  // Stimulus-side view of the current setting and of which pixels hold data
  logic [MODE_W-1:0] mir_mode;
  int                img_w, img_h, reg_l, reg_r, reg_t, reg_b;
  bit                written [DEPTH];
  int                written_list [$];
  bit                calm = 1'b0;
  int                stall_left = 0;
  int                cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  image_region_mirror_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  image_region_mirror_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL image_region_mirror_unit");
      $finish;
    end
  end

  // Result side backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 30);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int fold_size(logic [SIZE_W-1:0] v, int max_size);
    if (v == '0) return 1;
    return (int'(v) > max_size) ? max_size : int'(v);
  endfunction

  function automatic int fold_corner(logic signed [CORN_W-1:0] v, int size);
    int c;
    c = v;
    return (c < 0) ? 0 : ((c >= size) ? size - 1 : c);
  endfunction

  // Mirror map of the current region; it is its own inverse
  function automatic void mirror_of(input int col, input int row, output int mc,
                                    output int mr);
    mc = col;
    mr = row;
    if (reg_l <= reg_r && reg_t <= reg_b && col >= reg_l && col <= reg_r &&
        row >= reg_t && row <= reg_b) begin
      if (mir_mode == MODE_ROWS) mr = reg_b + reg_t - row;
      else if (mir_mode == MODE_COLS) mc = reg_r + reg_l - col;
    end
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic signed [CORN_W-1:0] lc,
                           logic signed [CORN_W-1:0] tr, logic signed [CORN_W-1:0] rc,
                           logic signed [CORN_W-1:0] br, logic [SIZE_W-1:0] w,
                           logic [SIZE_W-1:0] h);
    write_reg(CFG_MODE, CFG_W'(mode));
    write_reg(CFG_LEFT_COLUMN, lc);
    write_reg(CFG_TOP_ROW, tr);
    write_reg(CFG_RIGHT_COLUMN, rc);
    write_reg(CFG_BOTTOM_ROW, br);
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
    cfg_we   <= 1'b0;
    mir_mode = mode;
    img_w    = fold_size(w, MAX_WIDTH);
    img_h    = fold_size(h, MAX_HEIGHT);
    reg_l    = fold_corner(lc, img_w);
    reg_r    = fold_corner(rc, img_w);
    reg_t    = fold_corner(tr, img_h);
    reg_b    = fold_corner(br, img_h);
  endtask

  // Drop valid and wait for every result to drain
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_item(logic op, int col, int row, logic [PIX_W-1:0] rgb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_DATA_W'({rgb[7:0], rgb[15:8], rgb[23:16], CRD_W'(row), CRD_W'(col)});
    do @(posedge clk); while (!s_tready);
    if (op == OP_WRITE && col < img_w && row < img_h && !written[row * MAX_WIDTH + col]) begin
      written[row * MAX_WIDTH + col] = 1'b1;
      written_list.push_back(row * MAX_WIDTH + col);
    end
  endtask

  task automatic write_pixel(int col, int row);
    send_item(OP_WRITE, col, row, PIX_W'($urandom()));
  endtask

  // Read that never touches an unwritten entry: fill the source first if needed
  task automatic read_pixel(int col, int row);
    int sc, sr;
    mirror_of(col, row, sc, sr);
    if (col < img_w && row < img_h && !written[sr * MAX_WIDTH + sc]) write_pixel(sc, sr);
    send_item(OP_READ, col, row, PIX_W'($urandom()));
  endtask

  // Coordinate: mostly in the region or image, sometimes anywhere
  task automatic pick_coord(output int col, output int row);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && reg_l <= reg_r && reg_t <= reg_b) begin
      col = $urandom_range(reg_l, reg_r);
      row = $urandom_range(reg_t, reg_b);
    end else if (r < 80) begin
      col = $urandom_range(0, img_w - 1);
      row = $urandom_range(0, img_h - 1);
    end else begin
      col = $urandom_range(0, 511);
      row = $urandom_range(0, 511);
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SIZE_W'($urandom_range(1, 512));
    if (r < 7) return SIZE_W'(512);
    if (r == 7) return SIZE_W'($urandom_range(1, 8));
    if (r == 8) return SIZE_W'($urandom_range(513, 1023));
    return '0;
  endfunction

  function automatic logic signed [CORN_W-1:0] pick_corner(int size);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CORN_W'($urandom_range(0, size - 1));
    if (r == 7) return CORN_W'($urandom());
    if (r == 8) return CORN_W'(-$urandom_range(1, 40));
    return CORN_W'(size + $urandom_range(0, 3));
  endfunction

  task automatic random_config();
    logic [MODE_W-1:0]        mode;
    logic [SIZE_W-1:0]        w, h;
    logic signed [CORN_W-1:0] lc, rc, tr, br, tmp;
    int r;
    r = $urandom_range(0, 9);
    mode = (r < 4) ? MODE_ROWS : (r < 8) ? MODE_COLS : (r == 8) ? MODE_NONE : MODE_SPARE;
    w  = pick_size();
    h  = pick_size();
    lc = pick_corner(fold_size(w, MAX_WIDTH));
    rc = pick_corner(fold_size(w, MAX_WIDTH));
    tr = pick_corner(fold_size(h, MAX_HEIGHT));
    br = pick_corner(fold_size(h, MAX_HEIGHT));
    // keep most regions non-empty
    if (lc > rc && $urandom_range(0, 3) != 0) begin
      tmp = lc; lc = rc; rc = tmp;
    end
    if (tr > br && $urandom_range(0, 3) != 0) begin
      tmp = tr; tr = br; br = tmp;
    end
    configure(mode, lc, tr, rc, br, w, h);
  endtask

  initial begin
    int col, row, a, k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Corners of the full frame, plain reads
    configure(MODE_NONE, 0, 0, 0, 0, 512, 512);
    send_item(OP_WRITE, 0, 0, 24'hFFFFFF);
    send_item(OP_WRITE, 511, 511, 24'h000000);
    send_item(OP_WRITE, 511, 0, 24'h0F5AA5);
    send_item(OP_WRITE, 0, 511, 24'hF0A55A);
    read_pixel(0, 0);
    read_pixel(511, 511);
    read_pixel(511, 0);
    read_pixel(0, 511);

    // Row flip; width zero, oversized height, corners far outside
    settle();
    configure(MODE_ROWS, -32768, -1, 32767, 32767, 0, 1023);
    read_pixel(0, 0);
    read_pixel(0, 511);
    send_item(OP_WRITE, 1, 3, 24'h123456);
    read_pixel(300, 7);
    read_pixel(0, 200);

    // Column flip over a two-row image; corner equal to the size
    settle();
    configure(MODE_COLS, 0, 0, 512, 1, 1023, 2);
    read_pixel(0, 0);
    read_pixel(511, 0);
    read_pixel(5, 1);
    read_pixel(0, 2);

    // Unused mode code, then an empty region
    settle();
    configure(MODE_SPARE, 100, 0, 600, 511, 512, 512);
    read_pixel(300, 511);
    settle();
    configure(MODE_ROWS, 10, 0, 5, 511, 512, 512);
    read_pixel(7, 0);

    // Random phases, every fourth one without gaps or stalls
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      calm = (p % 4 == 3);
      random_config();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        k = $urandom_range(0, 99);
        if (k < 40) begin
          pick_coord(col, row);
          write_pixel(col, row);
        end else if (k < 75 && written_list.size() > 0) begin
          // read the mirror image of a stored pixel
          a = written_list[$urandom_range(0, written_list.size() - 1)];
          mirror_of(a % MAX_WIDTH, a / MAX_WIDTH, col, row);
          read_pixel(col, row);
        end else begin
          pick_coord(col, row);
          read_pixel(col, row);
        end
      end
    end

    calm = 1'b0;
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS image_region_mirror_unit");
    end else begin
      $display("FAIL image_region_mirror_unit");
    end
    $finish;
  end

endmodule

[image_region_mirror_unit.f]
design/imrm_pkg.sv
design/imrm_map.sv
design/imrm_ram.sv
design/image_region_mirror_unit.sv
test/image_region_mirror_checker.sv
test/tb_top.sv
